[hw/rtl/ias_pkg.sv]
// Shared types and constants for the interval activity selector.
`timescale 1ns / 1ps
`default_nettype none
package ias_pkg;

  localparam int MAX_INTERVALS = 64;
  localparam int TIME_BITS     = 16;
  localparam int PORT_TIME_W   = 16;
  localparam int OUT_CNT_W     = 7;
  localparam int CNT_W         = $clog2(MAX_INTERVALS + 1);
  localparam int OUT_CNT_MAX   = (1 << OUT_CNT_W) - 1;

  typedef logic [TIME_BITS-1:0] time_t;

  typedef struct packed {
    logic  vld;
    time_t t_start;
    time_t t_end;
  } cell_t;

  typedef enum logic [1:0] {
    CELL_HOLD   = 2'd0,
    CELL_INSERT = 2'd1,
    CELL_SHIFT  = 2'd2
  } cell_mode_t;

  typedef enum logic [1:0] {
    ST_LOAD = 2'b01,
    ST_SCAN = 2'b10
  } state_t;

endpackage
`default_nettype wire

[hw/rtl/ias_cell.sv]
// One cell of the ordered interval chain: insert in place or shift toward the head.
`timescale 1ns / 1ps
`default_nettype none
module ias_cell
  import ias_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire cell_mode_t mode,
  input  wire time_t      new_start,
  input  wire time_t      new_end,
  input  wire cell_t      prev_cell,
  input  wire logic       prev_gt,
  input  wire cell_t      next_cell,
  output cell_t           cell_q,
  output logic            gt
);

  cell_t cell_r;
  cell_t cell_nxt;

  assign gt     = !cell_r.vld || (cell_r.t_end > new_end);
  assign cell_q = cell_r;

  always_comb begin
    cell_nxt = cell_r;
    unique case (mode)
      CELL_INSERT: begin
        if (prev_gt) begin
          cell_nxt = prev_cell;
        end else if (gt) begin
          cell_nxt.vld     = 1'b1;
          cell_nxt.t_start = new_start;
          cell_nxt.t_end   = new_end;
        end
      end
      CELL_SHIFT: cell_nxt = next_cell;
      default:    cell_nxt = cell_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cell_r.vld <= 1'b0;
    end else begin
      cell_r.vld <= cell_nxt.vld;
    end
    cell_r.t_start <= cell_nxt.t_start;
    cell_r.t_end   <= cell_nxt.t_end;
  end

endmodule
`default_nettype wire

[hw/rtl/ias_scan.sv]
// Greedy earliest-finish scan over intervals leaving the head of the chain.
`timescale 1ns / 1ps
`default_nettype none
module ias_scan
  import ias_pkg::*;
(
  input  wire logic  clk,
  input  wire logic  rst_n,
  input  wire logic  step,
  input  wire logic  clr,
  input  wire cell_t head,
  output logic [CNT_W-1:0] picked
);

  logic             first_r;
  time_t            limit_r;
  logic [CNT_W-1:0] picked_r;

  assign picked = picked_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      first_r  <= 1'b1;
      picked_r <= '0;
    end else if (clr) begin
      first_r  <= 1'b1;
      picked_r <= '0;
    end else if (step && (first_r || head.t_start > limit_r)) begin
      first_r  <= 1'b0;
      picked_r <= picked_r + CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (step && (first_r || head.t_start > limit_r)) begin
      limit_r <= head.t_end;
    end
  end

endmodule
`default_nettype wire

[hw/rtl/interval_activity_selector_unit.sv]
// Top level of the interval activity selector.
// Input channel in_*: one request per interval (start, end, last marker).
// While loading, one interval is taken every cycle; it is placed by end time
// into a chain of MAX_INTERVALS cells, equal ends kept in arrival order.
// An interval that arrives while the chain is full is dropped and the
// overflow flag of the set is raised.
// After the request with in_last_item set, in_ready drops and the chain
// shifts its contents out through the greedy scan unit, one interval a
// cycle, and the result is registered once the chain is empty.
// Result channel out_*: one request per set, with the count picked
// (saturated to the field) and the overflow flag. The result sits in an
// output register; the next set may load while it waits. If the receiver
// still holds the previous result when a scan ends, the block waits.
// Reset empties the chain, clears the flags and the output valid; the result fields are not reset.
`timescale 1ns / 1ps
`default_nettype none
module interval_activity_selector_unit
  import ias_pkg::*;
(
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire logic                   in_valid,
  output logic                        in_ready,
  input  wire logic [PORT_TIME_W-1:0] in_start_time,
  input  wire logic [PORT_TIME_W-1:0] in_end_time,
  input  wire logic                   in_last_item,
  output logic                        out_valid,
  input  wire logic                   out_ready,
  output logic [OUT_CNT_W-1:0]        out_selected_count,
  output logic                        out_overflow
);

  state_t                state_r, state_nxt;
  logic                  ovf_r;
  logic                  out_valid_r;
  logic [OUT_CNT_W-1:0]  out_cnt_r;
  logic                  out_ovf_r;

  cell_t                 cells [MAX_INTERVALS];
  logic                  gts   [MAX_INTERVALS];
  cell_mode_t            mode;
  time_t                 new_start, new_end;
  logic                  in_acc, full, scan_step, finish;
  logic [CNT_W-1:0]      picked;
  logic [OUT_CNT_W-1:0]  picked_sat;

  assign new_start = in_start_time[TIME_BITS-1:0];
  assign new_end   = in_end_time[TIME_BITS-1:0];
  assign in_ready  = (state_r == ST_LOAD);
  assign in_acc    = in_valid && in_ready;
  assign full      = cells[MAX_INTERVALS-1].vld;
  assign scan_step = (state_r == ST_SCAN) && cells[0].vld;
  assign finish    = (state_r == ST_SCAN) && !cells[0].vld && (!out_valid_r || out_ready);

  always_comb begin
    if (in_acc && !full) begin
      mode = CELL_INSERT;
    end else if (scan_step) begin
      mode = CELL_SHIFT;
    end else begin
      mode = CELL_HOLD;
    end
  end

  for (genvar i = 0; i < MAX_INTERVALS; i++) begin : g_chain
    cell_t prev_c, next_c;
    logic  prev_g;
    if (i == 0) begin : g_head
      assign prev_c = '0;
      assign prev_g = 1'b0;
    end else begin : g_body
      assign prev_c = cells[i-1];
      assign prev_g = gts[i-1];
    end
    if (i == MAX_INTERVALS - 1) begin : g_tail
      assign next_c = '0;
    end else begin : g_mid
      assign next_c = cells[i+1];
    end
    ias_cell u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .mode      (mode),
      .new_start (new_start),
      .new_end   (new_end),
      .prev_cell (prev_c),
      .prev_gt   (prev_g),
      .next_cell (next_c),
      .cell_q    (cells[i]),
      .gt        (gts[i])
    );
  end

  ias_scan u_scan (
    .clk    (clk),
    .rst_n  (rst_n),
    .step   (scan_step),
    .clr    (finish),
    .head   (cells[0]),
    .picked (picked)
  );

  always_comb begin
    if (CNT_W > OUT_CNT_W && picked > CNT_W'(OUT_CNT_MAX)) begin
      picked_sat = OUT_CNT_W'(OUT_CNT_MAX);
    end else begin
      picked_sat = OUT_CNT_W'(picked);
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_LOAD: if (in_acc && in_last_item) state_nxt = ST_SCAN;
      ST_SCAN: if (finish) state_nxt = ST_LOAD;
      default: state_nxt = ST_LOAD;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_LOAD;
      ovf_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (finish) begin
        ovf_r <= 1'b0;
      end else if (in_acc && full) begin
        ovf_r <= 1'b1;
      end
      if (finish) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (finish) begin
      out_cnt_r <= picked_sat;
      out_ovf_r <= ovf_r;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_selected_count = out_cnt_r;
  assign out_overflow       = out_ovf_r;

endmodule
`default_nettype wire

[hw/rtl/ias_checker.sv]
// Port-level checker for the interval activity selector, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none
module ias_checker
  import ias_pkg::*;
(
  input wire logic                   clk,
  input wire logic                   rst_n,
  input wire logic                   in_valid,
  input wire logic                   in_ready,
  input wire logic                   in_last_item,
  input wire logic                   out_valid,
  input wire logic                   out_ready,
  input wire logic [OUT_CNT_W-1:0]   out_selected_count,
  input wire logic                   out_overflow
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_selected_count)
      && $stable(out_overflow))
    else $error("result changed while stalled");

  a_count_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_selected_count != '0)
    else $error("empty selection reported");

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_selected_count <= OUT_CNT_W'(MAX_INTERVALS > OUT_CNT_MAX ?
      OUT_CNT_MAX : MAX_INTERVALS))
    else $error("selection count above capacity");

  a_scan_blocks: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && in_last_item |=> !in_ready)
    else $error("input taken right after end of set");

endmodule

bind interval_activity_selector_unit ias_checker u_ias_checker (
  .clk                (clk),
  .rst_n              (rst_n),
  .in_valid           (in_valid),
  .in_ready           (in_ready),
  .in_last_item       (in_last_item),
  .out_valid          (out_valid),
  .out_ready          (out_ready),
  .out_selected_count (out_selected_count),
  .out_overflow       (out_overflow)
);
`default_nettype wire

[test/interval_activity_selector_unit_test.sv]
// Self-checking testbench for the interval activity selector unit.
`timescale 1ns / 1ps
module interval_activity_selector_unit_test;
  import ias_pkg::*;

  localparam int ITEM_TARGET = 1700;
  localparam int TAIL_ITEMS  = 250;
  localparam int LONG_HOLD   = 600;
  localparam int HOLD_AFTER  = 20;
  localparam int DRAIN       = 2 * MAX_INTERVALS + 16;
  localparam int CYCLE_LIMIT = 400000;

  typedef struct {
    logic [PORT_TIME_W-1:0] t_start;
    logic [PORT_TIME_W-1:0] t_end;
    logic                   last;
  } interval_req_t;

  typedef struct {
    logic [OUT_CNT_W-1:0] count;
    logic                 overflow;
  } tally_t;

  logic                   clk = 1'b0;
  logic                   rst_n = 1'b0;
  logic                   in_valid = 1'b0;
  logic                   in_ready;
  logic [PORT_TIME_W-1:0] in_start_time = '0;
  logic [PORT_TIME_W-1:0] in_end_time = '0;
  logic                   in_last_item = 1'b0;
  logic                   out_valid;
  logic                   out_ready = 1'b0;
  logic [OUT_CNT_W-1:0]   out_selected_count;
  logic                   out_overflow;

  interval_req_t interval_q[$];
  tally_t        tally_q[$];
  interval_req_t next_req;
  tally_t        got_tally;

  time_t held_start[MAX_INTERVALS];
  time_t held_end[MAX_INTERVALS];
  int    held_count = 0;
  logic  held_overflow = 1'b0;

  int   cycle_count = 0;
  int   in_gap = 0;
  int   ready_gap = 0;
  int   hold_left = 0;
  logic long_hold_done = 1'b0;
  logic quiet = 1'b0;
  int   sets_checked = 0;
  int   mismatch_count = 0;
  int   intervals_taken = 0;
  int   sets_sent = 0;
  int   overflow_sets = 0;
  int   widest_pick = 0;

  interval_activity_selector_unit dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_start_time     (in_start_time),
    .in_end_time       (in_end_time),
    .in_last_item      (in_last_item),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_selected_count(out_selected_count),
    .out_overflow      (out_overflow)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  always @(posedge clk) cycle_count <= cycle_count + 1;

  function automatic int greedy_pick_count();
    time_t reach;
    int    picked;
    reach = held_end[0];
    picked = 1;
    for (int i = 1; i < held_count; i++) begin
      if (held_start[i] > reach) begin
        reach = held_end[i];
        picked++;
      end
    end
    return picked;
  endfunction

  function automatic void record_interval(logic [PORT_TIME_W-1:0] s_in,
                                          logic [PORT_TIME_W-1:0] e_in, logic last);
    time_t  s;
    time_t  e;
    int     pos;
    int     picked;
    tally_t want;
    s = s_in;
    e = e_in;
    intervals_taken++;
    if (held_count >= MAX_INTERVALS) begin
      held_overflow = 1'b1;
    end else begin
      pos = held_count;
      while (pos > 0 && held_end[pos-1] > e) begin
        held_start[pos] = held_start[pos-1];
        held_end[pos] = held_end[pos-1];
        pos--;
      end
      held_start[pos] = s;
      held_end[pos] = e;
      held_count++;
    end
    if (last) begin
      picked = greedy_pick_count();
      if (picked > OUT_CNT_MAX) picked = OUT_CNT_MAX;
      if (picked > widest_pick) widest_pick = picked;
      if (held_overflow) overflow_sets++;
      want.count = picked[OUT_CNT_W-1:0];
      want.overflow = held_overflow;
      tally_q = {tally_q, want};
      sets_sent++;
      held_count = 0;
      held_overflow = 1'b0;
    end
  endfunction

  task automatic add_interval(int s, int e, bit last);
    interval_req_t r;
    r.t_start = s[PORT_TIME_W-1:0];
    r.t_end = e[PORT_TIME_W-1:0];
    r.last = last;
    interval_q = {interval_q, r};
  endtask

  task automatic add_random_set(int size);
    int mode;
    int s;
    int e;
    mode = $urandom_range(0, 2);
    for (int i = 0; i < size; i++) begin
      case (mode)
        0: begin
          s = $urandom_range(0, 65535);
          e = $urandom_range(0, 65535);
        end
        1: begin
          s = $urandom_range(0, 31);
          e = $urandom_range(0, 31);
        end
        default: begin
          s = $urandom_range(0, 65000);
          e = s + $urandom_range(0, 535);
        end
      endcase
      add_interval(s, e, i == size - 1);
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      in_gap <= 0;
      quiet <= 1'b0;
    end else begin
      quiet <= (interval_q.size() < TAIL_ITEMS);
      if (in_valid && in_ready) record_interval(in_start_time, in_end_time, in_last_item);
      if (!in_valid || in_ready) begin
        if (in_gap > 0) begin
          in_gap <= in_gap - 1;
          in_valid <= 1'b0;
        end else if (interval_q.size() == 0) begin
          in_valid <= 1'b0;
        end else if (!quiet && cycle_count[8] && $urandom_range(0, 4) == 0) begin
          in_gap <= $urandom_range(0, 7);
          in_valid <= 1'b0;
        end else begin
          next_req = interval_q.pop_front();
          in_valid <= 1'b1;
          in_start_time <= next_req.t_start;
          in_end_time <= next_req.t_end;
          in_last_item <= next_req.last;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
      ready_gap <= 0;
      hold_left <= 0;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_ready <= 1'b0;
    end else if (!long_hold_done && sets_checked >= HOLD_AFTER) begin
      long_hold_done <= 1'b1;
      hold_left <= LONG_HOLD;
      out_ready <= 1'b0;
    end else if (ready_gap > 0) begin
      ready_gap <= ready_gap - 1;
      out_ready <= 1'b0;
    end else if (!quiet && cycle_count[7] && $urandom_range(0, 4) == 0) begin
      ready_gap <= $urandom_range(0, 7);
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (tally_q.size() == 0) begin
        if (mismatch_count < 10)
          $display("unexpected result: count=%0d overflow=%0b",
                   out_selected_count, out_overflow);
        mismatch_count <= mismatch_count + 1;
      end else begin
        got_tally = tally_q.pop_front();
        if (out_selected_count !== got_tally.count || out_overflow !== got_tally.overflow) begin
          if (mismatch_count < 10)
            $display("set %0d: expected count=%0d overflow=%0b, got count=%0d overflow=%0b",
                     sets_checked, got_tally.count, got_tally.overflow,
                     out_selected_count, out_overflow);
          mismatch_count <= mismatch_count + 1;
        end
      end
      sets_checked <= sets_checked + 1;
    end
  end

  initial begin
    add_interval(0, 0, 1);
    add_interval(65535, 65535, 1);
    add_interval(16'hFFFF, 16'h0000, 1);
    add_interval(0, 10, 0);
    add_interval(10, 20, 0);
    add_interval(11, 30, 1);
    add_interval(9, 5, 0);
    add_interval(0, 5, 0);
    add_interval(6, 8, 1);
    add_interval(30, 40, 0);
    add_interval(20, 25, 0);
    add_interval(0, 10, 1);
    add_interval(16'hAAAA, 16'h5555, 0);
    add_interval(16'h5555, 16'hAAAA, 1);
    add_interval(0, 16'hFFFF, 0);
    add_interval(16'hFFFF, 16'hFFFF, 1);
    add_interval(7, 3, 0);
    add_interval(4, 3, 0);
    add_interval(2, 3, 1);
    add_random_set(MAX_INTERVALS - 1);
    add_random_set(MAX_INTERVALS);
    add_random_set(MAX_INTERVALS + 1);
    add_random_set(MAX_INTERVALS + 20);
    while (interval_q.size() < ITEM_TARGET) begin
      if ($urandom_range(0, 11) == 0) add_random_set($urandom_range(56, 72));
      else add_random_set($urandom_range(1, 10));
    end

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    while ((interval_q.size() != 0 || in_valid || tally_q.size() != 0)
           && cycle_count < CYCLE_LIMIT)
      @(posedge clk);

    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding",
               cycle_count, tally_q.size());
      $display("SCOREBOARD MISMATCH");
      $finish;
    end else begin
      repeat (DRAIN) @(posedge clk);
      $display("%0d intervals in %0d sets, %0d sets overflowed, up to %0d picked per set",
               intervals_taken, sets_sent, overflow_sets, widest_pick);
      $display("%0d results checked, %0d mismatches", sets_checked, mismatch_count);
      if (mismatch_count == 0 && tally_q.size() == 0)
        $display("SCOREBOARD CLEAN");
      else
        $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

endmodule
